[hdl/cslsm_pkg.sv]
// ----------------------------------------------------------------------------
// cslsm_pkg: shared types and constants of the scan monitor
// Channel plan, counter widths, configuration map, item and command formats.
// ----------------------------------------------------------------------------
package cslsm_pkg;

  // channel plan and counter sizing
  localparam int NUM_CHANNELS = 14;
  localparam int COUNT_BITS   = 24;

  // fixed field widths
  localparam int CH_W        = 4;
  localparam int RSSI_W      = 8;
  localparam int MAC_W       = 48;
  localparam int ROUND_W     = 32;
  localparam int OUT_TOTAL_W = 28;

  // running total holds up to sixteen full counters
  localparam int TOTAL_W = COUNT_BITS + 4;
  localparam int SLOT_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CMP_W   = (TOTAL_W > OUT_TOTAL_W) ? TOTAL_W : OUT_TOTAL_W;

  localparam logic [CH_W-1:0]        FIRST_CHANNEL = CH_W'(1);
  localparam logic [CH_W-1:0]        LAST_CHANNEL  = CH_W'(NUM_CHANNELS);
  localparam logic [OUT_TOTAL_W-1:0] OUT_TOTAL_MAX = '1;
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX     = '1;
  localparam logic signed [RSSI_W-1:0] RSSI_FLOOR_RST = -8'sd100;

  // queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // result queue at the output
  localparam int OUTQ_DEPTH = 2;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] REG_RSSI_FLOOR = '0;

  // classified operation of one word
  typedef enum logic [1:0] {
    OP_IGNORE,
    OP_MGMT,
    OP_HOP
  } op_t;

  typedef struct packed {
    logic                     req_type;
    logic                     is_mgmt;
    logic signed [RSSI_W-1:0] frame_rssi;
    logic [CH_W-1:0]          frame_channel;
    logic [MAC_W-1:0]         sender_mac;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]          cur_channel;
    logic [ROUND_W-1:0]       round_count;
    logic signed [RSSI_W-1:0] prev_best_rssi;
    logic [CH_W-1:0]          prev_best_channel;
    logic [MAC_W-1:0]         prev_best_mac;
    logic [OUT_TOTAL_W-1:0]   total_packets;
    logic                     round_done;
  } out_item_t;

  typedef struct packed {
    op_t                      op;
    logic signed [RSSI_W-1:0] rssi;
    logic [CH_W-1:0]          channel;
    logic [MAC_W-1:0]         mac;
  } cmd_t;

endpackage

[hdl/cslsm_front.sv]
// ----------------------------------------------------------------------------
// cslsm_front: intake, classification and command queue
// Holds the floor register, sorts each word into hop / management / ignore
// and buffers commands so the intake keeps going while the back end stalls.
// ----------------------------------------------------------------------------
module cslsm_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  output logic                                   full,
  input  cslsm_pkg::in_item_t                    in_data,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [cslsm_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [cslsm_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [cslsm_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                   pready,
  output logic signed [cslsm_pkg::RSSI_W-1:0]    rssi_floor,
  output logic                                   cmd_valid,
  output cslsm_pkg::cmd_t                        cmd,
  input  logic                                   cmd_take
);
  import cslsm_pkg::*;

  logic signed [RSSI_W-1:0] floor_r;
  logic                     floor_wr;
  logic                     floor_sel;

  cmd_t                     q_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0]    wr_ptr_r;
  logic [CMDQ_PTR_W-1:0]    rd_ptr_r;
  logic [CMDQ_CNT_W-1:0]    cnt_r;
  logic [CMDQ_CNT_W-1:0]    cnt_nxt;
  logic                     do_push;
  logic                     do_pop;
  cmd_t                     new_cmd;

  // register decode
  assign floor_sel = (paddr[CFG_ADDR_W-1:2] == REG_RSSI_FLOOR);
  assign floor_wr  = psel && penable && pwrite && pready && floor_sel;
  assign pready    = 1'b1;
  assign prdata    = floor_sel ? CFG_DATA_W'(floor_r) : '0;
  assign rssi_floor = floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= RSSI_FLOOR_RST;
    end else if (floor_wr) begin
      floor_r <= pwdata[RSSI_W-1:0];
    end
  end

  // classify the incoming word
  always_comb begin
    new_cmd.rssi    = in_data.frame_rssi;
    new_cmd.channel = in_data.frame_channel;
    new_cmd.mac     = in_data.sender_mac;
    if (in_data.req_type) begin
      new_cmd.op = OP_HOP;
    end else if (in_data.is_mgmt) begin
      new_cmd.op = OP_MGMT;
    end else begin
      new_cmd.op = OP_IGNORE;
    end
  end

  // command queue
  assign full      = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign do_push   = push && !full;
  assign cmd_valid = (cnt_r != '0);
  assign do_pop    = cmd_take && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CMDQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CMDQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                              : wr_ptr_r + CMDQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                              : rd_ptr_r + CMDQ_PTR_W'(1);
      end
    end
  end

  // queue storage, payload only
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

[hdl/cslsm_back.sv]
// ----------------------------------------------------------------------------
// cslsm_back: scan state update and result queue
// Applies one command a cycle, while the result queue has room or is being read,
// to the channel, counter and loudest-sender state, queuing its word for the output side.
// ----------------------------------------------------------------------------
module cslsm_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [cslsm_pkg::RSSI_W-1:0] rssi_floor,
  input  logic                                cmd_valid,
  input  cslsm_pkg::cmd_t                     cmd,
  output logic                                cmd_take,
  output logic                                empty,
  input  logic                                pop,
  output cslsm_pkg::out_item_t                out_data
);
  import cslsm_pkg::*;

  // scan state
  logic [CH_W-1:0]          channel_r,  channel_nxt;
  logic [COUNT_BITS-1:0]    pending_r,  pending_nxt;
  logic [COUNT_BITS-1:0]    counts_r [NUM_CHANNELS];
  logic [TOTAL_W-1:0]       total_r,    total_nxt;
  logic [ROUND_W-1:0]       rounds_r,   rounds_nxt;
  logic signed [RSSI_W-1:0] best_rssi_r, best_rssi_nxt;
  logic [CH_W-1:0]          best_ch_r,  best_ch_nxt;
  logic [MAC_W-1:0]         best_mac_r, best_mac_nxt;
  logic signed [RSSI_W-1:0] last_rssi_r, last_rssi_nxt;
  logic [CH_W-1:0]          last_ch_r,  last_ch_nxt;
  logic [MAC_W-1:0]         last_mac_r, last_mac_nxt;

  logic                     wrap;
  logic                     is_hop;
  logic [CH_W-1:0]          hop_ch;
  logic [SLOT_W-1:0]        old_slot;
  logic [SLOT_W-1:0]        new_slot;
  logic signed [RSSI_W-1:0] cmd_rssi;
  out_item_t                res;

  // result queue
  out_item_t                oq_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]    oq_wr_r;
  logic [OUTQ_PTR_W-1:0]    oq_rd_r;
  logic [OUTQ_CNT_W-1:0]    oq_cnt_r;
  logic                     oq_pop;

  assign empty    = (oq_cnt_r == '0);
  assign oq_pop   = pop && !empty;
  assign cmd_take = cmd_valid && ((oq_cnt_r != OUTQ_CNT_W'(OUTQ_DEPTH)) || oq_pop);
  assign out_data = oq_r[oq_rd_r];

  // channel stepping
  assign wrap     = (channel_r >= LAST_CHANNEL);
  assign hop_ch   = wrap ? FIRST_CHANNEL : channel_r + CH_W'(1);
  assign old_slot = SLOT_W'(channel_r - FIRST_CHANNEL);
  assign new_slot = SLOT_W'(hop_ch - FIRST_CHANNEL);
  assign is_hop   = (cmd.op == OP_HOP);
  assign cmd_rssi = cmd.rssi;

  // next scan state
  always_comb begin
    channel_nxt   = channel_r;
    pending_nxt   = pending_r;
    total_nxt     = total_r;
    rounds_nxt    = rounds_r;
    best_rssi_nxt = best_rssi_r;
    best_ch_nxt   = best_ch_r;
    best_mac_nxt  = best_mac_r;
    last_rssi_nxt = last_rssi_r;
    last_ch_nxt   = last_ch_r;
    last_mac_nxt  = last_mac_r;
    case (cmd.op)
      OP_HOP: begin
        pending_nxt = '0;
        channel_nxt = hop_ch;
        // slot being left was cleared on entry, so only the entered slot leaves the sum
        if (NUM_CHANNELS > 1) begin
          total_nxt = total_r + TOTAL_W'(pending_r) - TOTAL_W'(counts_r[new_slot]);
        end
        if (wrap) begin
          rounds_nxt    = rounds_r + ROUND_W'(1);
          last_rssi_nxt = best_rssi_r;
          last_ch_nxt   = best_ch_r;
          last_mac_nxt  = best_mac_r;
          best_rssi_nxt = rssi_floor;
          best_ch_nxt   = '0;
          best_mac_nxt  = '0;
        end
      end
      OP_MGMT: begin
        if (pending_r != COUNT_MAX) begin
          pending_nxt = pending_r + COUNT_BITS'(1);
        end
        if (cmd_rssi > best_rssi_r) begin
          best_rssi_nxt = cmd_rssi;
          best_ch_nxt   = cmd.channel;
          best_mac_nxt  = cmd.mac;
        end
      end
      default: ;
    endcase
  end

  // result word from the updated state
  always_comb begin
    res.cur_channel       = channel_nxt;
    res.round_count       = rounds_nxt;
    res.prev_best_rssi    = last_rssi_nxt;
    res.prev_best_channel = last_ch_nxt;
    res.prev_best_mac     = last_mac_nxt;
    res.total_packets     = (CMP_W'(total_nxt) > CMP_W'(OUT_TOTAL_MAX)) ? OUT_TOTAL_MAX
                                                                        : OUT_TOTAL_W'(total_nxt);
    res.round_done        = is_hop && wrap;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_r   <= FIRST_CHANNEL;
      pending_r   <= '0;
      total_r     <= '0;
      rounds_r    <= '0;
      best_rssi_r <= RSSI_FLOOR_RST;
      best_ch_r   <= '0;
      best_mac_r  <= '0;
      last_rssi_r <= RSSI_FLOOR_RST;
      last_ch_r   <= '0;
      last_mac_r  <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        counts_r[i] <= '0;
      end
    end else if (cmd_take) begin
      channel_r   <= channel_nxt;
      pending_r   <= pending_nxt;
      total_r     <= total_nxt;
      rounds_r    <= rounds_nxt;
      best_rssi_r <= best_rssi_nxt;
      best_ch_r   <= best_ch_nxt;
      best_mac_r  <= best_mac_nxt;
      last_rssi_r <= last_rssi_nxt;
      last_ch_r   <= last_ch_nxt;
      last_mac_r  <= last_mac_nxt;
      // store the left slot, then clear the entered one
      if (is_hop) begin
        counts_r[old_slot] <= pending_r;
        counts_r[new_slot] <= '0;
      end
    end
  end

  // result queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (cmd_take && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + OUTQ_CNT_W'(1);
      end else if (oq_pop && !cmd_take) begin
        oq_cnt_r <= oq_cnt_r - OUTQ_CNT_W'(1);
      end
      if (cmd_take) begin
        oq_wr_r <= (oq_wr_r == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : oq_wr_r + OUTQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= (oq_rd_r == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : oq_rd_r + OUTQ_PTR_W'(1);
      end
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      oq_r[oq_wr_r] <= res;
    end
  end

endmodule

[hdl/channel_scan_loudest_sender_monitor.sv]
// ----------------------------------------------------------------------------
// channel_scan_loudest_sender_monitor: channel-hopping scan monitor
// Counts management frames per channel and reports each round's loudest
// sender while the receiver hops across the channel plan.
// ----------------------------------------------------------------------------
// usage
//   input side: a queue write port. present a word on in_data with push high;
//   it is taken at a clock edge where full is low. a word is either a
//   received frame or a hop tick.
//   output side: a queue read port. while empty is low the oldest result word
//   is on out_data; pop high at a clock edge takes it. every input word gives
//   exactly one result word, in order.
//   configuration: register rssi_floor at byte address 0 over the apb-style
//   port. the user must write it only while the block is idle; the block
//   does not enforce this. it seeds the loudest-sender tracker at the start
//   of each round. timing: a taken word is held in the command queue until
//   the back end applies it, and its result is readable once in the result
//   queue. while pop stays high, one word per cycle is sustained both ways.
//   stalls: a 4-word command queue and a 2-word result queue let intake go on
//   while pop is held low; full rises once both queues have filled.
//   reset: synchronous, active low; both queues empty, channel 1, all counts
//   and rounds zero, floor back to -100. no clearing pass is needed.
// ----------------------------------------------------------------------------
module channel_scan_loudest_sender_monitor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  cslsm_pkg::in_item_t                 in_data,
  output logic                                empty,
  input  logic                                pop,
  output cslsm_pkg::out_item_t                out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cslsm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [cslsm_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [cslsm_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready
);
  import cslsm_pkg::*;

  logic signed [RSSI_W-1:0] rssi_floor;
  logic                     cmd_valid;
  logic                     cmd_take;
  cmd_t                     cmd;

  // intake and classification
  cslsm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .rssi_floor (rssi_floor),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  // state update and results
  cslsm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rssi_floor (rssi_floor),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data)
  );

endmodule

[hdl/cslsm_checker.sv]
// ----------------------------------------------------------------------------
// cslsm_checker: port-level checks of the scan monitor
// Watches the result side for channel range, round wrap and queue behavior.
// ----------------------------------------------------------------------------
module cslsm_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 empty,
  input logic                 pop,
  input cslsm_pkg::out_item_t out_data
);
  import cslsm_pkg::*;

  // reported channel stays within the plan
  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.cur_channel >= FIRST_CHANNEL) &&
               (out_data.cur_channel <= LAST_CHANNEL))
    else $error("cur_channel out of channel plan");

  // a completed round lands back on the first channel
  a_wrap_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.round_done) |-> (out_data.cur_channel == FIRST_CHANNEL))
    else $error("round_done without return to first channel");

  // a waiting word that is not taken stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("result word changed while stalled");

  // nothing to read right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> empty)
    else $error("results present right after reset");

endmodule

bind channel_scan_loudest_sender_monitor cslsm_checker u_cslsm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

[tb/tb_channel_scan_loudest_sender_monitor.sv]
// ----------------------------------------------------------------------------
// tb_channel_scan_loudest_sender_monitor: self-checking bench of the scan monitor
// Drives frames and hop ticks through the queue-style input, predicts every
// result word with a behavioral scan model, and compares each popped word
// field by field. Runs directed cases, random phases under several idle and
// stall mixes with different rssi floors, and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_channel_scan_loudest_sender_monitor;
  import cslsm_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_SHOWN   = 10;
  localparam int PHASE_WORDS = 340;
  localparam int HOLD_CYCLES = 200;
  localparam logic [CFG_ADDR_W-1:0] FLOOR_ADDR = {REG_RSSI_FLOOR, 2'b00};

  logic                  clk;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  in_item_t              in_data;
  logic                  empty;
  logic                  pop;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // scan model state
  int                       scan_chan;
  logic [COUNT_BITS-1:0]    pend_cnt;
  logic [COUNT_BITS-1:0]    slot_cnt [NUM_CHANNELS];
  longint unsigned          pkt_total;
  logic [ROUND_W-1:0]       round_cnt;
  logic signed [RSSI_W-1:0] floor_q;
  logic signed [RSSI_W-1:0] best_rssi_q;
  logic [CH_W-1:0]          best_ch_q;
  logic [MAC_W-1:0]         best_mac_q;
  logic signed [RSSI_W-1:0] last_rssi_q;
  logic [CH_W-1:0]          last_ch_q;
  logic [MAC_W-1:0]         last_mac_q;
  out_item_t                scan_expected [$];

  // run control and bookkeeping
  int idle_pct;
  int stall_pct;
  int hold_left;
  int cycles;
  int err_cnt;
  int words_sent;
  int words_checked;
  int hops_seen;
  int mgmt_seen;
  int rounds_seen;
  int floors_set;

  channel_scan_loudest_sender_monitor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int slot_idx(int ch);
    return (ch >= 1 && ch <= NUM_CHANNELS) ? ch - 1 : 0;
  endfunction

  task automatic store_slot(int idx, logic [COUNT_BITS-1:0] v);
    pkt_total = pkt_total - slot_cnt[idx] + v;
    slot_cnt[idx] = v;
  endtask

  task automatic reset_scan_model();
    floor_q     = RSSI_FLOOR_RST;
    scan_chan   = 1;
    pend_cnt    = '0;
    foreach (slot_cnt[i]) slot_cnt[i] = '0;
    pkt_total   = 0;
    round_cnt   = '0;
    best_rssi_q = RSSI_FLOOR_RST;
    best_ch_q   = '0;
    best_mac_q  = '0;
    last_rssi_q = RSSI_FLOOR_RST;
    last_ch_q   = '0;
    last_mac_q  = '0;
  endtask

  // advance the scan model by one accepted word and queue its result
  task automatic apply_word(in_item_t w);
    out_item_t r;
    logic      wrapped;
    wrapped = 1'b0;
    if (w.req_type) begin
      hops_seen++;
      store_slot(slot_idx(scan_chan), pend_cnt);
      pend_cnt = '0;
      scan_chan++;
      if (scan_chan > NUM_CHANNELS) begin
        scan_chan   = 1;
        round_cnt   = round_cnt + 1'b1;
        last_rssi_q = best_rssi_q;
        last_ch_q   = best_ch_q;
        last_mac_q  = best_mac_q;
        best_rssi_q = floor_q;
        best_ch_q   = '0;
        best_mac_q  = '0;
        wrapped     = 1'b1;
        rounds_seen++;
      end
      store_slot(slot_idx(scan_chan), '0);
    end else if (w.is_mgmt) begin
      mgmt_seen++;
      if (pend_cnt != COUNT_MAX) pend_cnt = pend_cnt + 1'b1;
      if ($signed(w.frame_rssi) > best_rssi_q) begin
        best_rssi_q = w.frame_rssi;
        best_ch_q   = w.frame_channel;
        best_mac_q  = w.sender_mac;
      end
    end
    r.cur_channel       = CH_W'(scan_chan);
    r.round_count       = round_cnt;
    r.prev_best_rssi    = last_rssi_q;
    r.prev_best_channel = last_ch_q;
    r.prev_best_mac     = last_mac_q;
    r.total_packets     = (pkt_total > OUT_TOTAL_MAX) ? OUT_TOTAL_MAX
                                                      : OUT_TOTAL_W'(pkt_total);
    r.round_done        = wrapped;
    scan_expected.push_back(r);
  endtask

  task automatic note_error(string msg);
    err_cnt++;
    if (err_cnt <= MAX_SHOWN) $display("[%0t] error: %s", $realtime, msg);
  endtask

  // compare one popped word against the oldest expectation
  task automatic check_result(out_item_t got);
    out_item_t want;
    string     bad;
    if (scan_expected.size() == 0) begin
      note_error($sformatf("result word with nothing expected: %p", got));
    end else begin
      want = scan_expected.pop_front();
      bad  = "";
      words_checked++;
      if (got.cur_channel       !== want.cur_channel)       bad = {bad, " cur_channel"};
      if (got.round_count       !== want.round_count)       bad = {bad, " round_count"};
      if (got.prev_best_rssi    !== want.prev_best_rssi)    bad = {bad, " prev_best_rssi"};
      if (got.prev_best_channel !== want.prev_best_channel) bad = {bad, " prev_best_channel"};
      if (got.prev_best_mac     !== want.prev_best_mac)     bad = {bad, " prev_best_mac"};
      if (got.total_packets     !== want.total_packets)     bad = {bad, " total_packets"};
      if (got.round_done        !== want.round_done)        bad = {bad, " round_done"};
      if (bad != "")
        note_error($sformatf("word %0d mismatch in%s\n  expected %p\n  actual   %p",
                             words_checked, bad, want, got));
    end
  endtask

  // sample both channels and the config port at the rising edge
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, scan_expected.size());
      $display("** channel_scan_loudest_sender_monitor: FAILED **");
      $finish;
    end else if (rst_n) begin
      if (push && !full) apply_word(in_data);
      if (pop && !empty) check_result(out_data);
      if (psel && penable && pwrite && pready && paddr == FLOOR_ADDR)
        floor_q = pwdata[RSSI_W-1:0];
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one word, with random idle cycles ahead of it, until it is taken
  task automatic send_word(in_item_t w);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push    <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (full);
    words_sent++;
  endtask

  // stop sending and wait until every expected word has come back
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (scan_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write the floor register, then read it back
  task automatic set_floor(logic [RSSI_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FLOOR_ADDR;
    pwdata  <= {{(CFG_DATA_W-RSSI_W){v[RSSI_W-1]}}, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[RSSI_W-1:0] !== v)
      note_error($sformatf("floor readback expected %h actual %h", v, prdata[RSSI_W-1:0]));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    floors_set++;
  endtask

  function automatic in_item_t mk_word(logic hop, logic mgmt, logic signed [RSSI_W-1:0] rssi,
                                       logic [CH_W-1:0] ch, logic [MAC_W-1:0] mac);
    in_item_t w;
    w.req_type      = hop;
    w.is_mgmt       = mgmt;
    w.frame_rssi    = rssi;
    w.frame_channel = ch;
    w.sender_mac    = mac;
    return w;
  endfunction

  // mostly management frames, a steady share of hops, some other frames;
  // half the rssi values sit right around the current best to hit ties
  function automatic in_item_t rand_word();
    in_item_t    w;
    int          pick;
    logic [63:0] m;
    pick            = $urandom_range(99);
    m               = {$urandom, $urandom};
    w.req_type      = (pick < 18);
    w.is_mgmt       = (pick < 18) ? 1'($urandom_range(1)) : (pick < 85);
    w.frame_rssi    = $urandom_range(1) ? RSSI_W'($urandom_range(255))
                                        : RSSI_W'(best_rssi_q + $urandom_range(4) - 2);
    w.frame_channel = CH_W'($urandom_range(15));
    w.sender_mac    = m[MAC_W-1:0];
    return w;
  endfunction

  // field extremes, ties, ignored frames and a hop carrying garbage fields
  task automatic test_frame_fields();
    send_word(mk_word(1'b0, 1'b1, -8'sd100, 4'd3, 48'h0000_0000_0001));
    send_word(mk_word(1'b0, 1'b1, -8'sd99, 4'd0, '0));
    send_word(mk_word(1'b0, 1'b0, 8'sd127, 4'd15, '1));
    send_word(mk_word(1'b0, 1'b1, -8'sd128, 4'd15, '1));
    send_word(mk_word(1'b0, 1'b1, 8'sd127, 4'd15, '1));
    send_word(mk_word(1'b0, 1'b1, 8'sd127, 4'd1, 48'h1234_5678_9abc));
    send_word(mk_word(1'b1, 1'b1, 8'sd127, 4'd15, '1));
  endtask

  // hop through the rest of the channel plan so the round wraps
  task automatic test_round_wrap();
    for (int i = 0; i < NUM_CHANNELS - 1; i++) begin
      send_word(mk_word(1'b1, 1'b0, '0, '0, '0));
      if (i == 3) send_word(mk_word(1'b0, 1'b1, -8'sd50, 4'd6, 48'h8000_0000_0000));
    end
    drain();
  endtask

  task automatic test_random_phase(int idle, int stall, logic [RSSI_W-1:0] fl, int n);
    set_floor(fl);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) send_word(rand_word());
    drain();
  endtask

  // hold the receiver off while words keep coming, so the block fills up
  task automatic test_backpressure();
    set_floor(RSSI_FLOOR_RST);
    idle_pct  = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 48; i++) send_word(rand_word());
    drain();
  endtask

  initial begin
    rst_n     = 1'b0;
    push      = 1'b0;
    in_data   = '0;
    pop       = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 0;
    cycles    = 0;
    err_cnt   = 0;
    words_sent    = 0;
    words_checked = 0;
    hops_seen     = 0;
    mgmt_seen     = 0;
    rounds_seen   = 0;
    floors_set    = 0;
    reset_scan_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_frame_fields();
    test_round_wrap();
    test_random_phase(0, 0, 8'h80, PHASE_WORDS);
    test_random_phase(59, 0, 8'h00, PHASE_WORDS);
    test_random_phase(0, 59, 8'h7F, PHASE_WORDS);
    test_random_phase(33, 33, RSSI_W'($urandom_range(255)), PHASE_WORDS);
    test_backpressure();
    drain();

    $display("covered %0d words (%0d hops, %0d management frames), %0d rounds wrapped,",
             words_sent, hops_seen, mgmt_seen, rounds_seen);
    $display("%0d floor settings, a %0d-cycle output hold-off; %0d results checked, %0d errors",
             floors_set, HOLD_CYCLES, words_checked, err_cnt);
    if (err_cnt == 0 && scan_expected.size() == 0) begin
      $display("** channel_scan_loudest_sender_monitor: PASSED **");
    end else begin
      $display("** channel_scan_loudest_sender_monitor: FAILED **");
    end
    $finish;
  end

endmodule
